// ===== design/doubly_linked_task_queue_macros.svh =====
// Assertion macros used by the task queue checker.
`ifndef DOUBLY_LINKED_TASK_QUEUE_MACROS_SVH
`define DOUBLY_LINKED_TASK_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DLTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DLTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dltq_pkg.sv =====
// Package: constants, codes and types of the doubly linked task queue.
package dltq_pkg;

    localparam int MAX_TASKS = 16;
    localparam int TASK_W    = $clog2(MAX_TASKS);
    localparam int LINK_W    = TASK_W + 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int REQ_W     = 2;
    localparam int STAT_W    = 2;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_TASKS);

    typedef logic [TASK_W-1:0] t_task;
    typedef logic [LINK_W-1:0] t_link;
    typedef logic [CNT_W-1:0]  t_count;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_DUP    = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_PUSH_LINK,
        S_UNLINK,
        S_RESP
    } t_state;

    function automatic logic is_task(t_link l);
        return l < LINK_W'(MAX_TASKS);
    endfunction

endpackage

// ===== design/doubly_linked_task_queue.sv =====
// Top level: task ready-queue kept as a doubly linked list in two link RAMs.
//
// Input channel (i_valid / o_stall): one request per item, i_req_type selects
// push of i_task_id at the tail, pop of the head, or removal of i_task_id from
// anywhere in the list. Code 3 is a no-op.
// Output channel (o_valid / i_stall): one result per request with the popped
// task, a status (ok, empty, duplicate push, absent task) and the count after
// the request.
// A request accepted in S_IDLE goes to S_DECIDE, then straight to S_RESP
// (reject, empty pop, no-op, push into an empty queue) or through S_PUSH_LINK
// (push behind a tail) or S_UNLINK (pop, remove); S_RESP loads the result
// into the output register. The next request is taken at the edge after the
// result enters the output register. The registered read of the link RAMs
// and the second write into the next-link RAM on a push call for these states.
// Reset (synchronous, i_rst_n low) empties the queue and clears all
// membership bits; the link RAMs need no clearing since an entry is always
// written by its push before it is read.
// A stalled result holds in the output register; a finished request then
// waits for the slot and the input stays stalled.
module doubly_linked_task_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_req_type,
    input  logic [3:0]             i_task_id,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [3:0]             o_popped_task,
    output logic                   o_popped_valid,
    output logic [1:0]             o_status,
    output logic [4:0]             o_queue_count
);
    import dltq_pkg::*;

    t_state  r_state, n_state;
    t_req    r_req, n_req;
    t_task   r_task, n_task;
    t_task   r_target, n_target;
    t_link   r_head, n_head;
    t_link   r_tail, n_tail;
    t_count  r_count, n_count;
    logic [MAX_TASKS-1:0] r_member, n_member;

    t_task   r_res_task, n_res_task;
    logic    r_res_pvalid, n_res_pvalid;
    t_status r_res_status, n_res_status;

    logic    r_o_valid, n_o_valid;
    t_task   r_o_task, n_o_task;
    logic    r_o_pvalid, n_o_pvalid;
    t_status r_o_status, n_o_status;
    t_count  r_o_count, n_o_count;

    logic  nx_we, pv_we;
    t_task nx_waddr, pv_waddr, rd_addr;
    t_link nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    dltq_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TASKS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (rd_addr),
        .o_rdata (nx_rdata)
    );

    dltq_ram #(.WIDTH(LINK_W), .DEPTH(MAX_TASKS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pv_rdata)
    );

    assign rd_addr = (r_req == REQ_POP) ? r_head[TASK_W-1:0] : r_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= NULL_LINK;
            r_tail    <= NULL_LINK;
            r_count   <= '0;
            r_member  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_member  <= n_member;
            r_o_valid <= n_o_valid;
        end
        r_req        <= n_req;
        r_task       <= n_task;
        r_target     <= n_target;
        r_res_task   <= n_res_task;
        r_res_pvalid <= n_res_pvalid;
        r_res_status <= n_res_status;
        r_o_task     <= n_o_task;
        r_o_pvalid   <= n_o_pvalid;
        r_o_status   <= n_o_status;
        r_o_count    <= n_o_count;
    end

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_task       = r_task;
        n_target     = r_target;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_member     = r_member;
        n_res_task   = r_res_task;
        n_res_pvalid = r_res_pvalid;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid && i_stall;
        n_o_task     = r_o_task;
        n_o_pvalid   = r_o_pvalid;
        n_o_status   = r_o_status;
        n_o_count    = r_o_count;
        nx_we        = 1'b0;
        nx_waddr     = r_task;
        nx_wdata     = NULL_LINK;
        pv_we        = 1'b0;
        pv_waddr     = r_task;
        pv_wdata     = r_tail;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req        = t_req'(i_req_type);
                    n_task       = i_task_id;
                    n_res_task   = '0;
                    n_res_pvalid = 1'b0;
                    n_res_status = ST_OK;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_RESP;
                case (r_req)
                    REQ_PUSH: begin
                        if (r_member[r_task]) begin
                            n_res_status = ST_DUP;
                        end else begin
                            nx_we = 1'b1;
                            pv_we = 1'b1;
                            if (is_task(r_tail)) begin
                                n_state = S_PUSH_LINK;
                            end else begin
                                n_head           = LINK_W'(r_task);
                                n_tail           = LINK_W'(r_task);
                                n_member[r_task] = 1'b1;
                                n_count          = r_count + 1'b1;
                            end
                        end
                    end
                    REQ_POP: begin
                        if (!is_task(r_head)) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_target     = r_head[TASK_W-1:0];
                            n_res_task   = r_head[TASK_W-1:0];
                            n_res_pvalid = 1'b1;
                            n_state      = S_UNLINK;
                        end
                    end
                    REQ_REMOVE: begin
                        if (!r_member[r_task]) begin
                            n_res_status = ST_ABSENT;
                        end else begin
                            n_target = r_task;
                            n_state  = S_UNLINK;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_PUSH_LINK: begin
                nx_we            = 1'b1;
                nx_waddr         = r_tail[TASK_W-1:0];
                nx_wdata         = LINK_W'(r_task);
                n_tail           = LINK_W'(r_task);
                n_member[r_task] = 1'b1;
                n_count          = r_count + 1'b1;
                n_state          = S_RESP;
            end
            S_UNLINK: begin
                if (r_head == LINK_W'(r_target)) begin
                    n_head = nx_rdata;
                end
                if (r_tail == LINK_W'(r_target)) begin
                    n_tail = pv_rdata;
                end
                nx_we              = is_task(pv_rdata);
                nx_waddr           = pv_rdata[TASK_W-1:0];
                nx_wdata           = nx_rdata;
                pv_we              = is_task(nx_rdata);
                pv_waddr           = nx_rdata[TASK_W-1:0];
                pv_wdata           = pv_rdata;
                n_member[r_target] = 1'b0;
                n_count            = r_count - 1'b1;
                n_state            = S_RESP;
            end
            S_RESP: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_task   = r_res_task;
                    n_o_pvalid = r_res_pvalid;
                    n_o_status = r_res_status;
                    n_o_count  = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_popped_task  = r_o_task;
    assign o_popped_valid = r_o_pvalid;
    assign o_status       = r_o_status;
    assign o_queue_count  = r_o_count;

endmodule

// ===== design/dltq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dltq_checker.sv =====
// Port-level checker for the task queue, bound to the top level.
`include "doubly_linked_task_queue_macros.svh"

module dltq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_req_type,
    input logic [3:0] i_task_id,
    input logic       o_valid,
    input logic       i_stall,
    input logic [3:0] o_popped_task,
    input logic       o_popped_valid,
    input logic [1:0] o_status,
    input logic [4:0] o_queue_count
);
    import dltq_pkg::*;

    `DLTQ_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_popped_task) && $stable(o_status) && $stable(o_queue_count), "stalled result changed")
    `DLTQ_ASSERT_NOW(a_pop_ok, o_valid && o_popped_valid, o_status == ST_OK, "popped task with error status")
    `DLTQ_ASSERT_NOW(a_empty_cnt, o_valid && o_status == ST_EMPTY, o_queue_count == '0 && !o_popped_valid, "empty pop with nonzero count")
    `DLTQ_ASSERT_NOW(a_cnt_max, o_valid, o_queue_count <= CNT_W'(MAX_TASKS), "count above capacity")

endmodule

bind doubly_linked_task_queue dltq_checker u_dltq_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the doubly linked task queue: directed and random push/pop/remove traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dltq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQUESTS = 500;

    typedef struct {
        t_req  req;
        t_task id;
    } t_request;

    typedef struct {
        t_task   popped_task;
        logic    popped_valid;
        t_status status;
        t_count  count;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [1:0] i_req_type = REQ_NOP;
    logic [3:0] i_task_id = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic [3:0] o_popped_task;
    logic o_popped_valid;
    logic [1:0] o_status;
    logic [4:0] o_queue_count;

    t_request pending_requests[$];
    t_result  expected_results[$];
    int       mismatches = 0;
    int       cycles = 0;

    // shadow list held by the testbench
    t_link  model_next[MAX_TASKS];
    t_link  model_prev[MAX_TASKS];
    t_link  model_head = NULL_LINK;
    t_link  model_tail = NULL_LINK;
    t_count model_count = '0;
    logic   model_member[MAX_TASKS];

    // list order as the generator sees it, used to aim removes at queued tasks and pushes at absent ones
    int          plan_order[$];
    bit [15:0]   plan_member = '0;

    doubly_linked_task_queue uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_task_id      (i_task_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_popped_task  (o_popped_task),
        .o_popped_valid (o_popped_valid),
        .o_status       (o_status),
        .o_queue_count  (o_queue_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit idle_now();
        if (cycles >= 400 && cycles < 1200) return 1'b0;
        return $urandom_range(99) < 17;
    endfunction

    function automatic void unlink_entry(t_task id);
        t_link n;
        t_link p;
        n = model_next[id];
        p = model_prev[id];
        if (model_head == t_link'(id)) model_head = n;
        if (model_tail == t_link'(id)) model_tail = p;
        if (p < MAX_TASKS) model_next[p[TASK_W-1:0]] = n;
        if (n < MAX_TASKS) model_prev[n[TASK_W-1:0]] = p;
        model_next[id] = NULL_LINK;
        model_prev[id] = NULL_LINK;
        model_member[id] = 1'b0;
        if (model_count > 0) model_count = model_count - 1'b1;
    endfunction

    function automatic t_result apply_request(t_req req, t_task id);
        t_result r;
        r.popped_task = '0;
        r.popped_valid = 1'b0;
        r.status = ST_OK;
        case (req)
            REQ_PUSH: begin
                if (model_member[id]) begin
                    r.status = ST_DUP;
                end else begin
                    model_next[id] = NULL_LINK;
                    model_prev[id] = NULL_LINK;
                    if (model_tail >= MAX_TASKS) begin
                        model_head = t_link'(id);
                        model_tail = t_link'(id);
                    end else begin
                        model_next[model_tail[TASK_W-1:0]] = t_link'(id);
                        model_prev[id] = model_tail;
                        model_tail = t_link'(id);
                    end
                    model_member[id] = 1'b1;
                    model_count = model_count + 1'b1;
                end
            end
            REQ_POP: begin
                if (model_head >= MAX_TASKS) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped_task = model_head[TASK_W-1:0];
                    r.popped_valid = 1'b1;
                    unlink_entry(model_head[TASK_W-1:0]);
                end
            end
            REQ_REMOVE: begin
                if (!model_member[id]) r.status = ST_ABSENT;
                else unlink_entry(id);
            end
            default: ;
        endcase
        r.count = model_count;
        return r;
    endfunction

    task automatic add_request(t_req req, int id);
        t_request q;
        int k;
        q.req = req;
        q.id = t_task'(id);
        pending_requests.push_back(q);
        case (req)
            REQ_PUSH: if (!plan_member[id]) begin
                plan_order.push_back(id);
                plan_member[id] = 1'b1;
            end
            REQ_POP: if (plan_order.size() > 0) begin
                k = plan_order.pop_front();
                plan_member[k] = 1'b0;
            end
            REQ_REMOVE: if (plan_member[id]) begin
                foreach (plan_order[j]) if (plan_order[j] == id) k = j;
                plan_order.delete(k);
                plan_member[id] = 1'b0;
            end
            default: ;
        endcase
    endtask

    initial begin
        int r;
        int push_weight;
        int id;
        foreach (model_next[j]) begin
            model_next[j] = NULL_LINK;
            model_prev[j] = NULL_LINK;
            model_member[j] = 1'b0;
        end

        // directed: empty pop, absent removes, duplicates, middle/head/tail unlink, no-op
        add_request(REQ_POP, 15);
        add_request(REQ_REMOVE, 0);
        add_request(REQ_REMOVE, 15);
        add_request(REQ_PUSH, 0);
        add_request(REQ_PUSH, 0);
        add_request(REQ_PUSH, 15);
        add_request(REQ_PUSH, 7);
        add_request(REQ_PUSH, 3);
        add_request(REQ_PUSH, 15);
        add_request(REQ_REMOVE, 15);
        add_request(REQ_REMOVE, 3);
        add_request(REQ_REMOVE, 0);
        add_request(REQ_NOP, 15);
        add_request(REQ_REMOVE, 7);
        add_request(REQ_REMOVE, 7);
        add_request(REQ_PUSH, 5);
        add_request(REQ_POP, 0);
        add_request(REQ_PUSH, 9);
        add_request(REQ_PUSH, 10);
        add_request(REQ_NOP, 0);
        add_request(REQ_POP, 5);
        add_request(REQ_POP, 0);
        add_request(REQ_POP, 0);
        add_request(REQ_PUSH, 15);
        add_request(REQ_REMOVE, 15);

        // random: alternate filling and draining phases so both count extremes are hit
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            push_weight = ((i / 60) % 2 == 0) ? 70 : 30;
            r = $urandom_range(99);
            if (r < 4) begin
                add_request(REQ_NOP, $urandom_range(15));
            end else if (r < 4 + push_weight) begin
                id = $urandom_range(15);
                if ($urandom_range(9) < 8 && plan_order.size() < MAX_TASKS)
                    while (plan_member[id]) id = $urandom_range(15);
                add_request(REQ_PUSH, id);
            end else if ($urandom_range(1) == 0) begin
                add_request(REQ_POP, $urandom_range(15));
            end else begin
                id = $urandom_range(15);
                if ($urandom_range(9) < 8 && plan_order.size() > 0)
                    id = plan_order[$urandom_range(plan_order.size() - 1)];
                add_request(REQ_REMOVE, id);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (pending_requests.size() != 0 || expected_results.size() != 0 || i_valid)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                expected_results.push_back(apply_request(t_req'(i_req_type), i_task_id));
                void'(pending_requests.pop_front());
            end
            if (pending_requests.size() > 0 && !idle_now()) begin
                i_valid <= 1'b1;
                i_req_type <= pending_requests[0].req;
                i_task_id <= pending_requests[0].id;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) i_stall <= 1'b0;
        else i_stall <= idle_now();
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: task %0d valid %0d status %0d count %0d",
                             o_popped_task, o_popped_valid, o_status, o_queue_count);
            end else begin
                e = expected_results.pop_front();
                if (o_popped_task !== e.popped_task || o_popped_valid !== e.popped_valid ||
                    o_status !== e.status || o_queue_count !== e.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected task %0d valid %0d status %0d count %0d,",
                                  " got task %0d valid %0d status %0d count %0d"},
                                 e.popped_task, e.popped_valid, e.status, e.count,
                                 o_popped_task, o_popped_valid, o_status, o_queue_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== doubly_linked_task_queue.f =====
+incdir+design
design/dltq_pkg.sv
design/dltq_ram.sv
design/doubly_linked_task_queue.sv
design/dltq_checker.sv
tb/testbench.sv
